// ----- design/mlfps_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfps_pkg
// Shared types, command codes and the microcode ROM of the slide block.
// ----------------------------------------------------------------------------
package mlfps_pkg;

    localparam int FRAC_BITS = 8;
    localparam logic [15:0] ROUND_HALF = 16'd128;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] CMD_PREPARE = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    typedef logic [2:0] t_uaddr;

    localparam t_uaddr UA_FETCH = 3'd0;
    localparam t_uaddr UA_PREP  = 3'd1;
    localparam t_uaddr UA_DIV   = 3'd2;
    localparam t_uaddr UA_DELTA = 3'd3;
    localparam t_uaddr UA_SET   = 3'd4;
    localparam t_uaddr UA_TINIT = 3'd5;
    localparam t_uaddr UA_LANE  = 3'd6;
    localparam t_uaddr UA_FLUSH = 3'd7;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_PREP,
        OP_DIV,
        OP_DELTA,
        OP_SET,
        OP_TINIT,
        OP_LANE,
        OP_FLUSH
    } t_op;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_LOOP
    } t_jmp;

    typedef struct packed {
        t_op    op;
        t_jmp   jmp;
        t_uaddr target;
    } t_uword;

    typedef struct packed {
        logic              beat;
        logic [1:0]        cmd;
        logic              stall;
        logic              loop_done;
    } t_stat;

    typedef struct packed {
        logic [2:0]        lane;
        logic signed [15:0] start_pos;
        logic signed [15:0] end_pos;
        logic signed [7:0] start_val;
        logic signed [7:0] end_val;
        logic [7:0]        lane_param;
        logic [3:0]        channel;
    } t_item;

    typedef struct packed {
        logic [7:0] param_number;
        logic [7:0] value;
        logic [3:0] out_channel;
        logic [2:0] lane_index;
        logic       last;
    } t_res;

    // A loop step repeats until the datapath reports its final pass, then
    // jumps to the target.
    function automatic t_uword ucode(input t_uaddr addr);
        t_uword w;
        case (addr)
            UA_FETCH: w = '{op: OP_FETCH, jmp: J_DISPATCH, target: UA_FETCH};
            UA_PREP:  w = '{op: OP_PREP,  jmp: J_NEXT,     target: UA_FETCH};
            UA_DIV:   w = '{op: OP_DIV,   jmp: J_LOOP,     target: UA_DELTA};
            UA_DELTA: w = '{op: OP_DELTA, jmp: J_GOTO,     target: UA_FETCH};
            UA_SET:   w = '{op: OP_SET,   jmp: J_GOTO,     target: UA_FETCH};
            UA_TINIT: w = '{op: OP_TINIT, jmp: J_NEXT,     target: UA_FETCH};
            UA_LANE:  w = '{op: OP_LANE,  jmp: J_LOOP,     target: UA_FLUSH};
            UA_FLUSH: w = '{op: OP_FLUSH, jmp: J_GOTO,     target: UA_FETCH};
            default:  w = '{op: OP_FETCH, jmp: J_DISPATCH, target: UA_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- design/mlfps_useq.sv -----
// ----------------------------------------------------------------------------
// mlfps_useq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module mlfps_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlfps_pkg::t_stat i_stat,
    output mlfps_pkg::t_uword o_uw
);
    import mlfps_pkg::*;

    t_uaddr r_step;
    t_uaddr n_step;
    t_uword uw;

    assign uw   = ucode(r_step);
    assign o_uw = uw;

    always_comb begin
        n_step = r_step;
        if (!i_stat.stall) begin
            case (uw.jmp)
                J_NEXT: n_step = r_step + 1'b1;
                J_GOTO: n_step = uw.target;
                J_DISPATCH: begin
                    if (i_stat.beat) begin
                        case (i_stat.cmd)
                            CMD_PREPARE: n_step = UA_PREP;
                            CMD_SET:     n_step = UA_SET;
                            CMD_TICK:    n_step = UA_TINIT;
                            default:     n_step = UA_FETCH;
                        endcase
                    end
                end
                J_LOOP: begin
                    if (i_stat.loop_done) begin
                        n_step = uw.target;
                    end
                end
                default: n_step = UA_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= UA_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- design/mlfps_div.sv -----
// ----------------------------------------------------------------------------
// mlfps_div
// Bit-serial restoring divider for the 8.8 step delta of a prepared slide.
// ----------------------------------------------------------------------------
module mlfps_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_step,
    input  mlfps_pkg::t_item i_item,
    output logic [15:0]      o_delta,
    output logic             o_last_step
);
    import mlfps_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_quo;
    logic [14:0]          r_rem;
    logic [14:0]          r_div;
    logic                 r_pos;
    logic                 r_neg;

    logic [15:0] steps;
    logic [8:0]  ydiff;
    logic [8:0]  ymag;
    logic [15:0] rem_sh;
    logic [15:0] rem_sub;
    logic        fits;

    assign steps   = i_item.end_pos - i_item.start_pos;
    assign ydiff   = {i_item.end_val[7], i_item.end_val}
                   - {i_item.start_val[7], i_item.start_val};
    assign ymag    = ydiff[8] ? (9'd0 - ydiff) : ydiff;
    assign rem_sh  = {r_rem, r_quo[15]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign fits    = rem_sh >= {1'b0, r_div};

    assign o_last_step = (r_cnt == DIV_CNT_W'(1));
    assign o_delta     = r_pos ? (r_neg ? (16'd0 - r_quo) : r_quo) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The magnitude is divided; the sign is put back at the end, which gives
    // truncation toward zero.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= {ymag[7:0], 8'h00};
            r_rem <= '0;
            r_div <= steps[14:0];
            r_pos <= !steps[15] && (steps != 16'd0);
            r_neg <= ydiff[8];
        end else if (i_step && r_cnt != '0) begin
            r_quo <= {r_quo[14:0], fits};
            r_rem <= fits ? rem_sub[14:0] : rem_sh[14:0];
        end
    end

endmodule

// ----- design/mlfps_lanes.sv -----
// ----------------------------------------------------------------------------
// mlfps_lanes
// Lane state registers and the per-lane datapath driven by the microcode.
// ----------------------------------------------------------------------------
module mlfps_lanes #(
    parameter int LANES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfps_pkg::t_uword i_uw,
    input  mlfps_pkg::t_item  i_item,
    input  logic [15:0]       i_delta,
    input  logic              i_out_free,
    output logic              o_stall,
    output logic              o_last_lane,
    output logic              o_push,
    output mlfps_pkg::t_res   o_res
);
    import mlfps_pkg::*;

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic signed [15:0] r_pos_now [LANES];
    logic signed [15:0] r_pos_end [LANES];
    logic [7:0]         r_val_start [LANES];
    logic [7:0]         r_val_end [LANES];
    logic [15:0]        r_acc [LANES];
    logic [15:0]        r_delta [LANES];
    logic [7:0]         r_slot [LANES];

    logic [LW-1:0] r_lane;
    logic          r_pend_v;
    t_res          r_pend;

    logic [LW-1:0]      w_lane;
    logic               in_range;
    logic signed [15:0] cur_now;
    logic signed [15:0] cur_end;
    logic [7:0]         cur_vs;
    logic [7:0]         cur_ve;
    logic [15:0]        cur_acc;
    logic [15:0]        cur_delta;
    logic [7:0]         cur_slot;
    logic               emit;
    logic [15:0]        acc_round;
    logic [7:0]         interp;
    logic [15:0]        acc_nx;
    logic signed [15:0] now_nx;
    logic               fin;
    logic [LW+2:0]      lane_ext;
    t_res               new_res;
    logic               is_lane;
    logic               is_flush;

    assign w_lane   = LW'(i_item.lane);
    assign in_range = {2'b00, i_item.lane} < 5'(LANES);

    assign cur_now   = r_pos_now[r_lane];
    assign cur_end   = r_pos_end[r_lane];
    assign cur_vs    = r_val_start[r_lane];
    assign cur_ve    = r_val_end[r_lane];
    assign cur_acc   = r_acc[r_lane];
    assign cur_delta = r_delta[r_lane];
    assign cur_slot  = r_slot[r_lane];

    assign emit      = (cur_slot != 8'd0) && (cur_now < cur_end);
    assign acc_round = cur_acc + ROUND_HALF;
    assign interp    = cur_vs + acc_round[15:FRAC_BITS];
    assign acc_nx    = cur_acc + cur_delta;
    assign now_nx    = cur_now + 16'sd1;
    assign fin       = now_nx >= cur_end;
    assign lane_ext  = (LW+3)'(r_lane);

    always_comb begin
        new_res.param_number = cur_slot - 8'd1;
        new_res.value        = fin ? cur_ve : interp;
        new_res.out_channel  = i_item.channel;
        new_res.lane_index   = lane_ext[2:0];
        new_res.last         = 1'b0;
    end

    assign is_lane  = (i_uw.op == OP_LANE);
    assign is_flush = (i_uw.op == OP_FLUSH);

    // A result is held back one emitting lane so that the final one of a tick
    // can be marked as last.
    assign o_stall = r_pend_v && !i_out_free && ((is_lane && emit) || is_flush);
    assign o_last_lane = (r_lane == LW'(LANES - 1));

    always_comb begin
        o_push = 1'b0;
        o_res  = r_pend;
        if (is_lane && emit && r_pend_v && i_out_free) begin
            o_push = 1'b1;
        end else if (is_flush && r_pend_v && i_out_free) begin
            o_push     = 1'b1;
            o_res.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane   <= '0;
            r_pend_v <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_pos_now[i]   <= '0;
                r_pos_end[i]   <= '0;
                r_val_start[i] <= '0;
                r_val_end[i]   <= '0;
                r_acc[i]       <= '0;
                r_delta[i]     <= '0;
                r_slot[i]      <= '0;
            end
        end else begin
            case (i_uw.op)
                OP_PREP: begin
                    if (in_range) begin
                        r_pos_now[w_lane]   <= i_item.start_pos;
                        r_pos_end[w_lane]   <= i_item.end_pos;
                        r_val_start[w_lane] <= i_item.start_val;
                        r_val_end[w_lane]   <= i_item.end_val;
                        r_acc[w_lane]       <= '0;
                    end
                end
                OP_DELTA: begin
                    if (in_range) begin
                        r_delta[w_lane] <= i_delta;
                    end
                end
                OP_SET: begin
                    if (in_range) begin
                        r_slot[w_lane] <= i_item.lane_param;
                    end
                end
                OP_TINIT: begin
                    r_lane   <= '0;
                    r_pend_v <= 1'b0;
                end
                OP_LANE: begin
                    if (!o_stall) begin
                        r_lane <= r_lane + 1'b1;
                        if (emit) begin
                            r_pend   <= new_res;
                            r_pend_v <= 1'b1;
                            if (fin) begin
                                r_pos_now[r_lane]   <= '0;
                                r_pos_end[r_lane]   <= '0;
                                r_val_start[r_lane] <= '0;
                                r_val_end[r_lane]   <= '0;
                                r_acc[r_lane]       <= '0;
                                r_delta[r_lane]     <= '0;
                            end else begin
                                r_acc[r_lane]     <= acc_nx;
                                r_pos_now[r_lane] <= now_nx;
                            end
                        end
                    end
                end
                OP_FLUSH: begin
                    if (r_pend_v && i_out_free) begin
                        r_pend_v <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- design/multi_lane_fixed_point_slide.sv -----
// ----------------------------------------------------------------------------
// multi_lane_fixed_point_slide
// Multi-lane linear slide with 8.8 fixed-point steps under microcode control.
// ----------------------------------------------------------------------------
// The slave stream carries commands: tuser selects prepare, set or tick, and
// tdata carries the lane and slide fields. The master stream returns one beat
// per emitting lane of a tick, in lane order, with tlast on the final beat.
// Prepare and set produce no beats; a tick with no running lane produces none.
// An input beat is taken only when the sequencer sits at its fetch step.
// A prepare runs through fetch, load, 16 divide steps and a delta write; the
// delta division yields one bit per cycle. A set runs through fetch and a
// slot write. A tick runs through fetch, setup, one visit per lane and a
// final flush; its first beat is registered for output when the next
// emitting lane is visited, its last beat at the flush.
// Results go through a single output register, so a new command is accepted
// while the last beat still waits. If the receiver holds tready low, the
// sequencer stalls at the lane or flush step that needs to hand over a beat.
// Synchronous reset clears all lane state, disables every lane and empties
// the output register.
// ----------------------------------------------------------------------------
module multi_lane_fixed_point_slide #(
    parameter int LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // lane, start_pos, end_pos, start_val, end_val, lane_param, channel
    input  logic [63:0] i_s_tdata,
    // cmd
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // param_number, value, out_channel, lane_index
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);
    import mlfps_pkg::*;

    t_uword uw;
    t_stat  stat;
    t_item  item;
    t_item  r_item;
    t_res   res;
    t_res   r_out;
    logic   r_out_v;
    logic   beat;
    logic   out_free;
    logic   push;
    logic   lane_stall;
    logic   lane_last;
    logic   div_last;
    logic [15:0] delta;

    always_comb begin
        item.lane       = i_s_tdata[2:0];
        item.start_pos  = i_s_tdata[18:3];
        item.end_pos    = i_s_tdata[34:19];
        item.start_val  = i_s_tdata[42:35];
        item.end_val    = i_s_tdata[50:43];
        item.lane_param = i_s_tdata[58:51];
        item.channel    = i_s_tdata[62:59];
    end

    assign o_s_tready = (uw.op == OP_FETCH);
    assign beat       = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_v || i_m_tready;

    always_comb begin
        stat.beat      = beat;
        stat.cmd       = i_s_tuser;
        stat.stall     = lane_stall;
        stat.loop_done = (uw.op == OP_DIV) ? div_last : lane_last;
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            r_item <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push) begin
            r_out_v <= 1'b1;
            r_out   <= res;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_out.lane_index, r_out.out_channel,
                         r_out.value, r_out.param_number};
    assign o_m_tlast  = r_out.last;

    mlfps_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uw    (uw)
    );

    mlfps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (uw.op == OP_PREP),
        .i_step      (uw.op == OP_DIV),
        .i_item      (r_item),
        .o_delta     (delta),
        .o_last_step (div_last)
    );

    mlfps_lanes #(
        .LANES (LANES)
    ) u_lanes (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (uw),
        .i_item      (r_item),
        .i_delta     (delta),
        .i_out_free  (out_free),
        .o_stall     (lane_stall),
        .o_last_lane (lane_last),
        .o_push      (push),
        .o_res       (res)
    );

endmodule
